[rtl/fcp_pkg.sv]
package fcp_pkg;

   // Fixed field widths
   localparam int COLOR_BITS = 8;
   localparam int CHANNELS   = 4;
   localparam int ENTRY_BITS = COLOR_BITS * CHANNELS;
   localparam int INDEX_BITS = 4;
   localparam int SCALE_BITS = 24;
   localparam int COUNT_BITS = 5;
   localparam int FRAC_BITS  = 16;

   // Register port geometry
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_SEL_BITS  = 2;

   typedef logic [CSR_SEL_BITS-1:0] csr_sel_type;

   localparam csr_sel_type REG_MIN_TEMP      = 2'd0;
   localparam csr_sel_type REG_STEP_SCALE    = 2'd1;
   localparam csr_sel_type REG_PALETTE_COUNT = 2'd2;

   // Command codes on the input channel
   localparam logic CMD_COLORIZE    = 1'b0;
   localparam logic CMD_WRITE_ENTRY = 1'b1;

   // Register values after reset
   localparam int                    MIN_TEMP_RESET      = 72;
   localparam logic [SCALE_BITS-1:0] STEP_SCALE_RESET    = 24'd8192;
   localparam logic [COUNT_BITS-1:0] PALETTE_COUNT_RESET = 5'd7;

   // Pixel beat leaving the palette read stage
   typedef struct packed {
      logic                  valid;
      logic [COLOR_BITS-1:0] weight;
   } mix_ctl_type;

endpackage

[rtl/fcp_if.sv]
interface fcp_req_if #(
   parameter int TEMP_BITS = 12
);
   logic                                  valid;
   logic                                  ready;
   logic                                  command;
   logic signed [TEMP_BITS-1:0]           temperature;
   logic [fcp_pkg::INDEX_BITS-1:0]        entry_index;
   logic [fcp_pkg::COLOR_BITS-1:0]        entry_red;
   logic [fcp_pkg::COLOR_BITS-1:0]        entry_green;
   logic [fcp_pkg::COLOR_BITS-1:0]        entry_blue;
   logic [fcp_pkg::COLOR_BITS-1:0]        entry_alpha;

   modport source (
      output valid, command, temperature, entry_index,
             entry_red, entry_green, entry_blue, entry_alpha,
      input  ready
   );

   modport sink (
      input  valid, command, temperature, entry_index,
             entry_red, entry_green, entry_blue, entry_alpha,
      output ready
   );
endinterface

interface fcp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [fcp_pkg::COLOR_BITS-1:0] red;
   logic [fcp_pkg::COLOR_BITS-1:0] green;
   logic [fcp_pkg::COLOR_BITS-1:0] blue;
   logic [fcp_pkg::COLOR_BITS-1:0] alpha;

   modport source (
      output valid, red, green, blue, alpha,
      input  ready
   );

   modport sink (
      input  valid, red, green, blue, alpha,
      output ready
   );
endinterface

[rtl/false_color_palette_interpolator.sv]
// False-color palette interpolator: thermal pixel in, RGBA color out.
// req_bus carries one beat per command. A write command (command = 1) loads
// one palette entry and gives no result; an index beyond the palette depth is
// dropped. A colorize command (command = 0) gives one beat on rsp_bus: the two
// palette entries around the scaled temperature, blended per channel.
// The csr_ port sets min_temp, step_scale and palette_count; write it only
// while no beat is in flight. Load palette entries before colorizing.
// The accepting edge of req_bus loads the subtract stage; multiply, palette
// read and the blend into the output register follow as registered stages up
// to rsp_bus valid. The pipe takes one beat every cycle while rsp_bus does not
// stall. A write issues in the same stage as pixel reads, so a pixel right
// after a write sees the new entry. The palette sits in two synchronous RAM
// copies with registered reads, one per neighbor. When rsp_bus stalls, every
// stage holds and req_bus ready drops in the same cycle; nothing is lost.
// Reset clears the pipeline and loads the register defaults; palette contents
// are not cleared and read as garbage until written.
module false_color_palette_interpolator #(
   parameter int PALETTE_DEPTH = 16,
   parameter int TEMP_BITS     = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   fcp_req_if.sink                            req_bus,
   fcp_rsp_if.source                          rsp_bus,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fcp_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [fcp_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [fcp_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   localparam int ADDR_BITS = $clog2(PALETTE_DEPTH);

   logic signed [TEMP_BITS-1:0]       min_temp;
   logic [fcp_pkg::SCALE_BITS-1:0]    step_scale;
   logic [fcp_pkg::COUNT_BITS-1:0]    palette_count;
   logic                              advance;
   logic                              wr_en;
   logic [ADDR_BITS-1:0]              wr_addr;
   logic [fcp_pkg::ENTRY_BITS-1:0]    wr_data;
   logic [ADDR_BITS-1:0]              rd_addr_lo, rd_addr_hi;
   logic [fcp_pkg::ENTRY_BITS-1:0]    entry_lo, entry_hi;
   fcp_pkg::mix_ctl_type              mix_ctl;

   fcp_csr #(
      .TEMP_BITS (TEMP_BITS)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .min_temp      (min_temp),
      .step_scale    (step_scale),
      .palette_count (palette_count)
   );

   fcp_front #(
      .TEMP_BITS     (TEMP_BITS),
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .req           (req_bus),
      .min_temp      (min_temp),
      .step_scale    (step_scale),
      .palette_count (palette_count),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_addr_lo    (rd_addr_lo),
      .rd_addr_hi    (rd_addr_hi),
      .mix_ctl       (mix_ctl)
   );

   // Lower neighbor copy of the palette
   fcp_ram #(
      .WIDTH (fcp_pkg::ENTRY_BITS),
      .DEPTH (PALETTE_DEPTH)
   ) u_ram_lo (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (advance),
      .rd_addr (rd_addr_lo),
      .rd_data (entry_lo)
   );

   // Upper neighbor copy of the palette
   fcp_ram #(
      .WIDTH (fcp_pkg::ENTRY_BITS),
      .DEPTH (PALETTE_DEPTH)
   ) u_ram_hi (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (advance),
      .rd_addr (rd_addr_hi),
      .rd_data (entry_hi)
   );

   fcp_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .mix_ctl  (mix_ctl),
      .entry_lo (entry_lo),
      .entry_hi (entry_hi),
      .advance  (advance),
      .rsp      (rsp_bus)
   );

endmodule

[rtl/fcp_ram.sv]
module fcp_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fcp_csr.sv]
module fcp_csr #(
   parameter int TEMP_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fcp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [fcp_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [fcp_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready,
   output logic signed [TEMP_BITS-1:0]         min_temp,
   output logic [fcp_pkg::SCALE_BITS-1:0]      step_scale,
   output logic [fcp_pkg::COUNT_BITS-1:0]      palette_count
);

   logic signed [TEMP_BITS-1:0]         min_temp_ff;
   logic [fcp_pkg::SCALE_BITS-1:0]      step_scale_ff;
   logic [fcp_pkg::COUNT_BITS-1:0]      palette_count_ff;
   logic                                write_beat;
   fcp_pkg::csr_sel_type                sel;

   assign sel        = csr_paddr[fcp_pkg::CSR_ADDR_BITS-1:2];
   assign write_beat = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   // Update the addressed register on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         min_temp_ff      <= TEMP_BITS'(fcp_pkg::MIN_TEMP_RESET);
         step_scale_ff    <= fcp_pkg::STEP_SCALE_RESET;
         palette_count_ff <= fcp_pkg::PALETTE_COUNT_RESET;
      end else if (write_beat) begin
         unique case (sel)
            fcp_pkg::REG_MIN_TEMP:      min_temp_ff <= csr_pwdata[TEMP_BITS-1:0];
            fcp_pkg::REG_STEP_SCALE: begin
               step_scale_ff <= csr_pwdata[fcp_pkg::SCALE_BITS-1:0];
            end
            fcp_pkg::REG_PALETTE_COUNT: begin
               palette_count_ff <= csr_pwdata[fcp_pkg::COUNT_BITS-1:0];
            end
            default: ;
         endcase
      end
   end

   // Read back, min_temp sign extended
   always_comb begin
      unique case (sel)
         fcp_pkg::REG_MIN_TEMP:      csr_prdata = fcp_pkg::CSR_DATA_BITS'(min_temp_ff);
         fcp_pkg::REG_STEP_SCALE:    csr_prdata = fcp_pkg::CSR_DATA_BITS'(step_scale_ff);
         fcp_pkg::REG_PALETTE_COUNT: csr_prdata = fcp_pkg::CSR_DATA_BITS'(palette_count_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   assign min_temp      = min_temp_ff;
   assign step_scale    = step_scale_ff;
   assign palette_count = palette_count_ff;

endmodule

[rtl/fcp_front.sv]
module fcp_front #(
   parameter int  TEMP_BITS     = 12,
   parameter int  PALETTE_DEPTH = 16,
   localparam int ADDR_BITS     = $clog2(PALETTE_DEPTH)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   fcp_req_if.sink                           req,
   input  logic signed [TEMP_BITS-1:0]       min_temp,
   input  logic [fcp_pkg::SCALE_BITS-1:0]    step_scale,
   input  logic [fcp_pkg::COUNT_BITS-1:0]    palette_count,
   output logic                              wr_en,
   output logic [ADDR_BITS-1:0]              wr_addr,
   output logic [fcp_pkg::ENTRY_BITS-1:0]    wr_data,
   output logic [ADDR_BITS-1:0]              rd_addr_lo,
   output logic [ADDR_BITS-1:0]              rd_addr_hi,
   output fcp_pkg::mix_ctl_type              mix_ctl
);

   localparam int DIFF_BITS    = TEMP_BITS + 1;
   localparam int PROD_BITS    = DIFF_BITS + fcp_pkg::SCALE_BITS + 1;
   localparam int POS_BITS     = PROD_BITS - fcp_pkg::FRAC_BITS;
   localparam int CNT_BITS     = ADDR_BITS + fcp_pkg::COUNT_BITS + 1;
   localparam int IDX_EXT_BITS = ADDR_BITS + fcp_pkg::INDEX_BITS;

   typedef struct packed {
      logic valid;
      logic write;
   } stage_ctl_type;

   stage_ctl_type                     a_ctl_in, a_ctl_ff, b_ctl_ff;
   logic signed [DIFF_BITS-1:0]       a_diff_in, a_diff_ff;
   logic [fcp_pkg::INDEX_BITS-1:0]    a_index_ff, b_index_ff;
   logic [fcp_pkg::ENTRY_BITS-1:0]    a_color_ff, b_color_ff;
   logic signed [fcp_pkg::SCALE_BITS:0] scale_signed;
   logic signed [PROD_BITS-1:0]       b_prod_in, b_prod_ff;
   fcp_pkg::mix_ctl_type              mix_ctl_in, mix_ctl_ff;

   logic signed [POS_BITS-1:0]        pos;
   logic signed [POS_BITS-1:0]        last_pos;
   logic [CNT_BITS-1:0]               count_ext, used, last_ext;
   logic [ADDR_BITS-1:0]              last_addr;
   logic                              below, above, at_last;
   logic [IDX_EXT_BITS-1:0]           index_ext;
   logic                              index_ok;

   // Take a beat whenever the whole pipe moves
   assign req.ready      = advance & ~reset;
   assign a_ctl_in.valid = req.valid & req.ready;
   assign a_ctl_in.write = (req.command == fcp_pkg::CMD_WRITE_ENTRY);
   assign a_diff_in      = DIFF_BITS'(req.temperature) - DIFF_BITS'(min_temp);

   // Position in Q.16: difference times palette steps per temperature unit
   assign scale_signed = $signed({1'b0, step_scale});
   assign b_prod_in    = a_diff_ff * scale_signed;

   // Leave the read stage only with pixel beats
   assign mix_ctl_in.valid  = b_ctl_ff.valid & ~b_ctl_ff.write;
   assign mix_ctl_in.weight = b_prod_ff[fcp_pkg::FRAC_BITS-1 -: fcp_pkg::COLOR_BITS];

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff   <= '0;
         b_ctl_ff   <= '0;
         mix_ctl_ff <= '0;
      end else if (advance) begin
         a_ctl_ff   <= a_ctl_in;
         b_ctl_ff   <= a_ctl_ff;
         mix_ctl_ff <= mix_ctl_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         a_diff_ff  <= a_diff_in;
         a_index_ff <= req.entry_index;
         a_color_ff <= {req.entry_red, req.entry_green, req.entry_blue, req.entry_alpha};
         b_prod_ff  <= b_prod_in;
         b_index_ff <= a_index_ff;
         b_color_ff <= a_color_ff;
      end
   end

   // Effective entry count: zero acts as one, saturate at the depth
   assign count_ext = CNT_BITS'(palette_count);
   always_comb begin
      priority if (count_ext == '0) begin
         used = CNT_BITS'(1);
      end else if (count_ext > CNT_BITS'(PALETTE_DEPTH)) begin
         used = CNT_BITS'(PALETTE_DEPTH);
      end else begin
         used = count_ext;
      end
   end
   assign last_ext  = used - CNT_BITS'(1);
   assign last_addr = last_ext[ADDR_BITS-1:0];
   assign last_pos  = $signed(POS_BITS'(last_ext));

   // Clamp the lower and upper neighbor into the entries in use
   assign pos     = $signed(b_prod_ff[PROD_BITS-1:fcp_pkg::FRAC_BITS]);
   assign below   = pos[POS_BITS-1];
   assign above   = pos > last_pos;
   assign at_last = pos >= last_pos;

   always_comb begin
      priority if (below) begin
         rd_addr_lo = '0;
         rd_addr_hi = '0;
      end else if (above) begin
         rd_addr_lo = last_addr;
         rd_addr_hi = last_addr;
      end else if (at_last) begin
         rd_addr_lo = pos[ADDR_BITS-1:0];
         rd_addr_hi = last_addr;
      end else begin
         rd_addr_lo = pos[ADDR_BITS-1:0];
         rd_addr_hi = pos[ADDR_BITS-1:0] + ADDR_BITS'(1);
      end
   end

   // Palette writes land in the same stage as pixel reads, so order holds
   assign index_ext = IDX_EXT_BITS'(b_index_ff);
   assign index_ok  = index_ext < IDX_EXT_BITS'(PALETTE_DEPTH);
   assign wr_en     = advance & b_ctl_ff.valid & b_ctl_ff.write & index_ok;
   assign wr_addr   = index_ext[ADDR_BITS-1:0];
   assign wr_data   = b_color_ff;

   assign mix_ctl = mix_ctl_ff;

endmodule

[rtl/fcp_blend.sv]
module fcp_blend (
   input  logic                            clock,
   input  logic                            reset,
   input  fcp_pkg::mix_ctl_type            mix_ctl,
   input  logic [fcp_pkg::ENTRY_BITS-1:0]  entry_lo,
   input  logic [fcp_pkg::ENTRY_BITS-1:0]  entry_hi,
   output logic                            advance,
   fcp_rsp_if.source                       rsp
);

   localparam int CB = fcp_pkg::COLOR_BITS;

   logic                            rsp_valid_ff;
   logic [fcp_pkg::ENTRY_BITS-1:0]  color_in, color_ff;

   // Move when the output register is empty or being drained
   assign advance = ~rsp_valid_ff | rsp.ready;

   // One lane per channel: lo*256 + (hi - lo)*w + half, keep bits 15:8
   for (genvar lane = 0; lane < fcp_pkg::CHANNELS; lane++) begin : g_lane
      logic [CB-1:0]           c_lo, c_hi;
      logic signed [CB:0]      delta;
      logic signed [2*CB+1:0]  scaled, base, total;

      assign c_lo   = entry_lo[lane*CB +: CB];
      assign c_hi   = entry_hi[lane*CB +: CB];
      assign delta  = $signed({1'b0, c_hi}) - $signed({1'b0, c_lo});
      assign scaled = delta * $signed({1'b0, mix_ctl.weight});
      assign base   = $signed({2'b00, c_lo, 1'b1, {(CB-1){1'b0}}});
      assign total  = base + scaled;
      assign color_in[lane*CB +: CB] = total[2*CB-1:CB];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mix_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         color_ff <= color_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.red   = color_ff[4*CB-1:3*CB];
   assign rsp.green = color_ff[3*CB-1:2*CB];
   assign rsp.blue  = color_ff[2*CB-1:CB];
   assign rsp.alpha = color_ff[CB-1:0];

endmodule

[rtl/fcp_checker.sv]
module fcp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [fcp_pkg::COLOR_BITS-1:0] rsp_red,
   input logic                           csr_pready
);

   // Reset empties the output register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   // An empty output register never blocks input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // A draining output register never blocks input
   a_ready_when_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |-> req_ready)
      else $error("input stalled while output drains");

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_red)))
      else $error("stalled result beat changed");

   // Register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      (req_valid || !req_valid) |-> csr_pready)
      else $error("register port not ready");

endmodule

bind false_color_palette_interpolator fcp_checker u_fcp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_red    (rsp_bus.red),
   .csr_pready (csr_pready)
);
